// ===== rtl/bqr_pkg.sv =====
// Shared widths, opcodes and status codes for the bounded queue with search and remove.
package bqr_pkg;

    localparam int DATA_W        = 8;
    localparam int OP_W          = 2;
    localparam int STATUS_W      = 3;
    localparam int COUNT_W       = 5;
    localparam int CAP_W         = 5;
    localparam int DEPTH_DEFAULT = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP    = 2'd2;
    localparam logic [OP_W-1:0] OP_DUMP_IF = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISMATCH  = 3'd4;

endpackage

// ===== rtl/bqr_cfg_if.sv =====
// Configuration write channel carrying the capacity register value.
interface bqr_cfg_if
    import bqr_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/bqr_cmd_if.sv =====
// Command channel: one opcode and one character per transaction.
interface bqr_cmd_if
    import bqr_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   opcode;
    logic [DATA_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

// ===== rtl/bqr_rsp_if.sv =====
// Result channel: status, dumped entry, entry count and last flag.
interface bqr_rsp_if
    import bqr_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                item_valid;
    logic [DATA_W-1:0]   item;
    logic [COUNT_W-1:0]  count;
    logic                last;

    modport source (output valid, output status, output item_valid, output item,
                    output count, output last, input ready);
    modport sink   (input valid, input status, input item_valid, input item,
                    input count, input last, output ready);
endinterface

// ===== rtl/bounded_queue_remove_by_value_core.sv =====
// Top level: sequencer of the bounded queue with search, remove and dump.
//
// The queue keeps up to DEPTH characters in arrival order in a single-port-read memory, and
// one comparator on the memory read data is stepped over the entries by a small sequencer.
// The command channel is ready only while the sequencer is idle. A remove reads the entries
// from the head until one matches, then moves each later entry one place lower; a dump of n
// entries delivers one result per cycle while the result channel accepts them, and a
// conditional dump first checks the head entry against the command character. A result
// register sits on the result channel, and back-pressure there stalls the sequencer. The
// capacity register may be written at any time through the configuration channel, which is
// always ready.
module bounded_queue_remove_by_value_core
    import bqr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic         clk,
    input  logic         rst_n,
    bqr_cfg_if.sink      cfg,
    bqr_cmd_if.sink      cmd,
    bqr_rsp_if.source    rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > CAP_W) ? CW : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EMIT,
        S_SEARCH,
        S_SHIFT,
        S_MOVE,
        S_HEAD,
        S_DUMP
    } state_t;

    state_t              state_reg, state_next;
    logic [CAP_W-1:0]    capacity_reg, capacity_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    logic [STATUS_W-1:0] status_reg, status_next;

    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] rsp_status_reg, rsp_status_next;
    logic                rsp_item_valid_reg, rsp_item_valid_next;
    logic [DATA_W-1:0]   rsp_item_reg, rsp_item_next;
    logic [COUNT_W-1:0]  rsp_count_reg, rsp_count_next;
    logic                rsp_last_reg, rsp_last_next;

    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [DATA_W-1:0]   wr_data;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic [DATA_W-1:0]   rd_data;

    logic [LW-1:0]       limit;
    logic [CW-1:0]       idx_plus;
    logic [AW-1:0]       idx_inc;
    logic                emit_ok;
    logic                hit;

    bqr_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg.ready      = 1'b1;
    assign cmd.ready      = (state_reg == S_IDLE);

    assign rsp.valid      = rsp_valid_reg;
    assign rsp.status     = rsp_status_reg;
    assign rsp.item_valid = rsp_item_valid_reg;
    assign rsp.item       = rsp_item_reg;
    assign rsp.count      = rsp_count_reg;
    assign rsp.last       = rsp_last_reg;

    assign limit    = (LW'(capacity_reg) < LW'(DEPTH)) ? LW'(capacity_reg) : LW'(DEPTH);
    assign idx_plus = CW'(idx_reg) + CW'(1);
    assign idx_inc  = idx_plus[AW-1:0];
    assign emit_ok  = !rsp_valid_reg || rsp.ready;
    // The one shared comparator: memory read data against the command character.
    assign hit      = (rd_data == val_reg);

    always_comb
    begin
        state_next          = state_reg;
        capacity_next       = capacity_reg;
        count_next          = count_reg;
        idx_next            = idx_reg;
        val_next            = val_reg;
        status_next         = status_reg;
        rsp_valid_next      = rsp_valid_reg;
        rsp_status_next     = rsp_status_reg;
        rsp_item_valid_next = rsp_item_valid_reg;
        rsp_item_next       = rsp_item_reg;
        rsp_count_next      = rsp_count_reg;
        rsp_last_next       = rsp_last_reg;
        wr_en               = 1'b0;
        wr_addr             = idx_reg;
        wr_data             = val_reg;
        rd_en               = 1'b0;
        rd_addr             = idx_inc;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        if (cfg.valid)
        begin
            capacity_next = cfg.data;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    val_next = cmd.value;
                    idx_next = '0;
                    unique case (cmd.opcode)
                        OP_PUSH:
                        begin
                            state_next = S_EMIT;
                            if (LW'(count_reg) >= limit)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[AW-1:0];
                                wr_data     = cmd.value;
                                count_next  = count_reg + CW'(1);
                                status_next = ST_OK;
                            end
                        end
                        OP_REMOVE, OP_DUMP, OP_DUMP_IF:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_EMIT;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                                if (cmd.opcode == OP_REMOVE)
                                begin
                                    state_next = S_SEARCH;
                                end
                                else if (cmd.opcode == OP_DUMP)
                                begin
                                    state_next = S_DUMP;
                                end
                                else
                                begin
                                    state_next = S_HEAD;
                                end
                            end
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    state_next = S_SHIFT;
                end
                else if (idx_plus == count_reg)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_EMIT;
                end
                else
                begin
                    idx_next = idx_inc;
                    rd_en    = 1'b1;
                    rd_addr  = idx_inc;
                end
            end

            // Close the gap: each later entry is read and then written one place lower.
            S_SHIFT:
            begin
                if (idx_plus >= count_reg)
                begin
                    count_next  = count_reg - CW'(1);
                    status_next = ST_OK;
                    state_next  = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc;
                    state_next = S_MOVE;
                end
            end

            S_MOVE:
            begin
                wr_en      = 1'b1;
                wr_addr    = idx_reg;
                wr_data    = rd_data;
                idx_next   = idx_inc;
                state_next = S_SHIFT;
            end

            S_HEAD:
            begin
                if (hit)
                begin
                    state_next = S_DUMP;
                end
                else
                begin
                    status_next = ST_MISMATCH;
                    state_next  = S_EMIT;
                end
            end

            S_DUMP:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_status_next     = ST_OK;
                    rsp_item_valid_next = 1'b1;
                    rsp_item_next       = rd_data;
                    rsp_count_next      = COUNT_W'(count_reg);
                    rsp_last_next       = (idx_plus == count_reg);
                    if (idx_plus == count_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_inc;
                        rd_en    = 1'b1;
                        rd_addr  = idx_inc;
                    end
                end
            end

            S_EMIT:
            begin
                if (emit_ok)
                begin
                    rsp_valid_next      = 1'b1;
                    rsp_status_next     = status_reg;
                    rsp_item_valid_next = 1'b0;
                    rsp_item_next       = '0;
                    rsp_count_next      = COUNT_W'(count_reg);
                    rsp_last_next       = 1'b1;
                    state_next          = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            capacity_reg  <= capacity_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg            <= idx_next;
        val_reg            <= val_next;
        status_reg         <= status_next;
        rsp_status_reg     <= rsp_status_next;
        rsp_item_valid_reg <= rsp_item_valid_next;
        rsp_item_reg       <= rsp_item_next;
        rsp_count_reg      <= rsp_count_next;
        rsp_last_reg       <= rsp_last_next;
    end

endmodule

// ===== rtl/bqr_store.sv =====
// Entry memory: one write port and one read port with registered read data.
module bqr_store
    import bqr_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled dump keeps its entry.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
